// ===== rtl/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque package
// Operation and status codes, controller states and the cell select codes
// shared by the deque modules.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WORD_W   = 32;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LIST       = 3'd4;

  // Status codes of a result transaction.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  // What the row of cells does as a whole in one cycle.
  typedef enum logic [2:0] {
    ROW_HOLD,
    ROW_PUSH_FRONT,
    ROW_PUSH_BACK,
    ROW_POP_FRONT,
    ROW_ROTATE
  } row_op_e;

  // Where one cell takes its next word from.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_TAKE_PUSH,
    CELL_TAKE_HEAD
  } cell_op_e;

endpackage

// ===== rtl/dq_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque request channel
// Valid/ready channel carrying one operation request per transaction.
// ----------------------------------------------------------------------------
interface dq_in_if
  import dq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== rtl/dq_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface dq_out_if
  import dq_pkg::*;
#(
  parameter int unsigned CNT_W = 5
);
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] element;
  logic [STATUS_W-1:0]      status;
  logic [CNT_W-1:0]         count;
  logic                     last;

  modport source (output valid, output element, output status, output count,
                  output last, input ready);
  modport sink   (input valid, input element, input status, input count,
                  input last, output ready);
endinterface

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of words held in a row of shifting cells with an element
// count, serving push and pop at both ends and an in-order listing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_i, one operation per transaction: push front,
//   push back, pop front, pop back or list. Results leave on out_o.
//   Push and pop each give one result transaction with a status (ok, empty,
//   or full with the push refused) and the element count after the request.
//   A list gives one result per stored element, front to back, with last set
//   on the final one; listing an empty queue gives a single empty result.
//   Request codes 5 to 7 are dropped without a result.
// Latency and throughput:
//   A push or pop result is registered and appears in the cycle after its
//   request is taken; pushes and pops are taken one per cycle while out_o
//   is not stalled. A list enters the listing state, then emits the stored
//   elements in turn as the row rotates by one position per element, so the
//   row ends up in its original order. No request is taken during a list.
// Reset and stalls:
//   Reset empties the queue and drops any pending result. While out_o is
//   stalled the result register holds and in_i.ready stays low; the stored
//   words are never cleared, only the count says which cells are live.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Control state.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] remain_q, remain_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   element_q, element_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [CNT_W-1:0]    res_count_q, res_count_d;
  logic                last_q, last_d;
  logic                out_load;

  logic     out_free;
  logic     in_accept;
  logic     is_full;
  logic     is_empty;
  row_op_e  row_op;

  logic [CNT_W-1:0]      tail_idx;
  logic [DATA_WIDTH-1:0] push_word;
  logic [WORD_W-1:0]     head_word;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  // A new request is taken only while idle and the result register is free
  // or being emptied in this cycle.
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_accept = in_i.valid && in_i.ready;

  assign is_full  = (count_q == CNT_FULL);
  assign is_empty = (count_q == '0);
  assign tail_idx = count_q - CNT_ONE;

  // Width adaptation between the 32-bit ports and the stored words.
  generate
    if (DATA_WIDTH <= WORD_W) begin : g_narrow
      assign push_word = in_i.value[DATA_WIDTH-1:0];
      if (DATA_WIDTH == WORD_W) begin : g_same
        assign head_word = cell_data[0];
      end else begin : g_pad
        assign head_word = {{(WORD_W - DATA_WIDTH){1'b0}}, cell_data[0]};
      end
    end else begin : g_wide
      assign push_word = {{(DATA_WIDTH - WORD_W){1'b0}}, in_i.value};
      assign head_word = cell_data[0][WORD_W-1:0];
    end
  endgenerate

  // Next-state logic: queue count, listing counter and controller state.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    remain_d = remain_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_i.func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              if (!is_full) begin
                count_d = count_q + CNT_ONE;
              end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
              if (!is_empty) begin
                count_d = count_q - CNT_ONE;
              end
            end
            FUNC_LIST: begin
              if (!is_empty) begin
                state_d  = ST_LIST;
                remain_d = count_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          remain_d = remain_q - CNT_ONE;
          if (remain_q == CNT_ONE) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output logic: row operation and the result to be registered.
  always_comb begin
    row_op      = ROW_HOLD;
    out_load    = 1'b0;
    element_d   = '0;
    status_d    = STATUS_OK;
    res_count_d = count_q;
    last_d      = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_i.func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              out_load = 1'b1;
              if (is_full) begin
                status_d = STATUS_FULL;
              end else begin
                row_op      = (in_i.func == FUNC_PUSH_FRONT) ? ROW_PUSH_FRONT
                                                             : ROW_PUSH_BACK;
                res_count_d = count_q + CNT_ONE;
              end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
              out_load = 1'b1;
              if (is_empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                // A pop at the back only shortens the count.
                if (in_i.func == FUNC_POP_FRONT) begin
                  row_op = ROW_POP_FRONT;
                end
                res_count_d = count_q - CNT_ONE;
              end
            end
            FUNC_LIST: begin
              if (is_empty) begin
                out_load = 1'b1;
                status_d = STATUS_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          // Emit the head and rotate it to the tail of the live cells.
          out_load  = 1'b1;
          row_op    = ROW_ROTATE;
          element_d = head_word;
          last_d    = (remain_q == CNT_ONE);
        end
      end
      default: begin
      end
    endcase
  end

  // Per-cell select decode and the row of storage cells.
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_word;
      logic [DATA_WIDTH-1:0] right_word;
      cell_op_e              cell_sel;

      if (i == 0) begin : g_first
        assign left_word = push_word;
      end else begin : g_inner_left
        assign left_word = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_final
        assign right_word = cell_data[i];
      end else begin : g_inner_right
        assign right_word = cell_data[i+1];
      end

      always_comb begin
        case (row_op)
          ROW_PUSH_FRONT: cell_sel = (i == 0) ? CELL_TAKE_PUSH : CELL_TAKE_LEFT;
          ROW_PUSH_BACK:  cell_sel = (count_q == CNT_W'(i)) ? CELL_TAKE_PUSH
                                                            : CELL_HOLD;
          ROW_POP_FRONT:  cell_sel = CELL_TAKE_RIGHT;
          ROW_ROTATE:     cell_sel = (tail_idx == CNT_W'(i)) ? CELL_TAKE_HEAD
                                                             : CELL_TAKE_RIGHT;
          default:        cell_sel = CELL_HOLD;
        endcase
      end

      dq_cell #(
        .WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk_i  (clk_i),
        .op_i   (cell_sel),
        .left_i (left_word),
        .right_i(right_word),
        .push_i (push_word),
        .head_i (cell_data[0]),
        .data_o (cell_data[i])
      );
    end
  endgenerate

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      element_q   <= element_d;
      status_q    <= status_d;
      res_count_q <= res_count_d;
      last_q      <= last_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.element = element_q;
  assign out_o.status  = status_q;
  assign out_o.count   = res_count_q;
  assign out_o.last    = last_q;

`ifndef SYNTHESIS
  // The element count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("deque count exceeds depth");

  // While listing, the elements still to emit stay within the live count.
  a_list_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> (remain_q != '0) && (remain_q <= count_q))
    else $error("list counter out of range");

  // A list leaves the controller idle right after its final element.
  a_list_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) && out_free && (remain_q == CNT_ONE)
    |=> (state_q == ST_IDLE) && out_o.valid && out_o.last)
    else $error("list did not end on its final element");

  // The count does not move during a list.
  a_list_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |=> $stable(count_q))
    else $error("count changed during a list");
`endif

endmodule

// ===== rtl/dq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque storage cell
// One word of the deque; each cycle it keeps its word or takes one from a
// neighbor, the push port or the head of the row.
// ----------------------------------------------------------------------------
module dq_cell
  import dq_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  cell_op_e         op_i,
  input  logic [WIDTH-1:0] left_i,
  input  logic [WIDTH-1:0] right_i,
  input  logic [WIDTH-1:0] push_i,
  input  logic [WIDTH-1:0] head_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q;
  logic [WIDTH-1:0] data_d;

  always_comb begin
    case (op_i)
      CELL_TAKE_LEFT:  data_d = left_i;
      CELL_TAKE_RIGHT: data_d = right_i;
      CELL_TAKE_PUSH:  data_d = push_i;
      CELL_TAKE_HEAD:  data_d = head_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
